// ===== hw/rtl/sgbs_pkg.sv =====
package sgbs_pkg;

  localparam int BLOCK_SHIFT = 4;
  localparam int DIR_SHIFT   = 6;
  localparam int POOL_BLOCKS = 64;

  localparam int COORD_W = 10;
  localparam int VALUE_W = 8;

  localparam int SLOT_W    = 2 * DIR_SHIFT;
  localparam int CELL_W    = 2 * BLOCK_SHIFT;
  localparam int BLK_W     = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
  localparam int USED_W    = $clog2(POOL_BLOCKS + 1);
  localparam int CELL_AW   = BLK_W + CELL_W;
  localparam int DIR_DEPTH = 1 << SLOT_W;
  localparam int STORE_DEPTH = 1 << CELL_AW;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [BLK_W-1:0] blk;
  } dir_entry_t;

  localparam int DIR_W = $bits(dir_entry_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_READ,
    S_FILL,
    S_DONE
  } state_t;

  function automatic logic [SLOT_W-1:0] slot_of(logic [COORD_W-1:0] x,
                                                logic [COORD_W-1:0] y);
    logic [DIR_SHIFT-1:0] bx;
    logic [DIR_SHIFT-1:0] by;
    bx = DIR_SHIFT'(x >> BLOCK_SHIFT);
    by = DIR_SHIFT'(y >> BLOCK_SHIFT);
    return {bx, by};
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(logic [COORD_W-1:0] x,
                                                logic [COORD_W-1:0] y);
    logic [BLOCK_SHIFT-1:0] cx;
    logic [BLOCK_SHIFT-1:0] cy;
    cx = BLOCK_SHIFT'(x);
    cy = BLOCK_SHIFT'(y);
    return {cx, cy};
  endfunction

endpackage

// ===== hw/rtl/sgbs_ram.sv =====
module sgbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/sparse_grid_block_store.sv =====
// Two-level sparse byte grid. Each request reads or writes one byte cell at (x, y): the
// coordinate bits above the block size select one of 4096 directory slots and the low
// bits select a cell in that block. A read of a slot never written returns zero; the
// first write to a slot takes the next of 64 pool blocks, zeroes its 256 cells and
// stores the byte, and once the pool is used up such a write is dropped with status 1.
// Both tables sit in synchronous RAMs with one write and one read port. A write to an
// allocated block reads the directory entry, then writes the cell; a read reads the
// entry, then the cell; a write that allocates a block writes the new entry, then
// clears all 256 cells of the block, storing the byte in its cell. After reset the block
// runs a clearing pass over the directory and holds in_stall high until it ends. The
// result register holds a finished result under out_stall while the next request is taken.
module sparse_grid_block_store
  import sgbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [COORD_W-1:0] in_x_coord,
  input  logic [COORD_W-1:0] in_y_coord,
  input  logic [VALUE_W-1:0] in_write_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] out_read_value,
  output logic               out_status
);

  state_t state_r, state_nxt;

  logic [SLOT_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [USED_W-1:0]  used_r, used_nxt;
  logic [CELL_W-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic [BLK_W-1:0]   blk_r, blk_nxt;
  logic               func_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [CELL_W-1:0]  cell_r;
  logic [VALUE_W-1:0] val_r;
  logic [VALUE_W-1:0] res_rd_r;
  logic               res_st_r;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] out_rd_r;
  logic               out_st_r;

  logic               in_accept;
  logic               out_free;
  logic               fin;
  logic [VALUE_W-1:0] fin_rd;
  logic               fin_st;
  logic               pool_full;

  logic               dir_we;
  logic [SLOT_W-1:0]  dir_waddr;
  logic [DIR_W-1:0]   dir_wdata;
  logic               dir_re;
  logic [DIR_W-1:0]   dir_rdata;
  dir_entry_t         entry;

  logic               cell_we;
  logic [CELL_AW-1:0] cell_waddr;
  logic [VALUE_W-1:0] cell_wdata;
  logic               cell_re;
  logic [CELL_AW-1:0] cell_raddr;
  logic [VALUE_W-1:0] cell_rdata;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign entry     = dir_entry_t'(dir_rdata);
  assign pool_full = (used_r == USED_W'(POOL_BLOCKS));

  sgbs_ram #(
    .WIDTH (DIR_W),
    .DEPTH (DIR_DEPTH)
  ) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .re    (dir_re),
    .raddr (slot_of(in_x_coord, in_y_coord)),
    .rdata (dir_rdata)
  );

  sgbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (func_r == FUNC_READ && entry.valid) begin
          state_nxt = S_READ;
        end else if (func_r == FUNC_WRITE && !entry.valid && !pool_full) begin
          state_nxt = S_FILL;
        end else begin
          state_nxt = out_free ? S_IDLE : S_DONE;
        end
      end
      S_READ: begin
        state_nxt = out_free ? S_IDLE : S_DONE;
      end
      S_FILL: begin
        if (fill_cnt_r == '1) begin
          state_nxt = out_free ? S_IDLE : S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = out_free ? S_IDLE : S_DONE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    fin          = 1'b0;
    fin_rd       = '0;
    fin_st       = STATUS_DONE;
    dir_we       = 1'b0;
    dir_waddr    = slot_r;
    dir_wdata    = '0;
    dir_re       = in_accept;
    cell_we      = 1'b0;
    cell_waddr   = {entry.blk, cell_r};
    cell_wdata   = val_r;
    cell_re      = 1'b0;
    cell_raddr   = {entry.blk, cell_r};
    clr_cnt_nxt  = clr_cnt_r;
    used_nxt     = used_r;
    fill_cnt_nxt = fill_cnt_r;
    blk_nxt      = blk_r;
    unique case (state_r)
      S_CLEAR: begin
        dir_we      = 1'b1;
        dir_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      S_IDLE: begin
      end
      S_LOOKUP: begin
        if (func_r == FUNC_READ) begin
          if (entry.valid) begin
            cell_re = 1'b1;
          end else begin
            fin = 1'b1;
          end
        end else if (entry.valid) begin
          cell_we = 1'b1;
          fin     = 1'b1;
        end else if (pool_full) begin
          fin    = 1'b1;
          fin_st = STATUS_DROPPED;
        end else begin
          dir_we       = 1'b1;
          dir_wdata    = {1'b1, BLK_W'(used_r)};
          blk_nxt      = BLK_W'(used_r);
          used_nxt     = used_r + 1'b1;
          fill_cnt_nxt = '0;
        end
      end
      S_READ: begin
        fin    = 1'b1;
        fin_rd = cell_rdata;
      end
      S_FILL: begin
        cell_we      = 1'b1;
        cell_waddr   = {blk_r, fill_cnt_r};
        cell_wdata   = (fill_cnt_r == cell_r) ? val_r : '0;
        fill_cnt_nxt = fill_cnt_r + 1'b1;
        fin          = (fill_cnt_r == '1);
      end
      S_DONE: begin
        fin    = 1'b1;
        fin_rd = res_rd_r;
        fin_st = res_st_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      used_r      <= '0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      used_r      <= used_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    if (in_accept) begin
      func_r <= in_func;
      slot_r <= slot_of(in_x_coord, in_y_coord);
      cell_r <= cell_of(in_x_coord, in_y_coord);
      val_r  <= in_write_value;
    end
    if (fin) begin
      res_rd_r <= fin_rd;
      res_st_r <= fin_st;
    end
    if (fin && out_free) begin
      out_rd_r <= fin_rd;
      out_st_r <= fin_st;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rd_r;
  assign out_status     = out_st_r;

endmodule

// ===== verif/sgbs_checker.sv =====
module sgbs_checker
  import sgbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_func,
  input  logic [COORD_W-1:0] in_x_coord,
  input  logic [COORD_W-1:0] in_y_coord,
  input  logic [VALUE_W-1:0] in_write_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [VALUE_W-1:0] out_read_value,
  input  logic               out_status,
  output int                 mismatches,
  output int                 pending,
  output int                 results_checked,
  output int                 writes_dropped,
  output int                 blocks_allocated
);

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               status;
  } grid_result_t;

  logic               slot_used  [DIR_DEPTH];
  logic [BLK_W-1:0]   slot_block [DIR_DEPTH];
  logic [VALUE_W-1:0] grid_cells [STORE_DEPTH];
  int                 pool_taken;
  int                 drop_count;
  int                 requests_seen;
  grid_result_t       grid_result_q[$];

  assign pending          = requests_seen - results_checked;
  assign writes_dropped   = drop_count;
  assign blocks_allocated = pool_taken;

  function automatic grid_result_t grid_access(logic f, logic [COORD_W-1:0] x,
                                               logic [COORD_W-1:0] y,
                                               logic [VALUE_W-1:0] v);
    logic [DIR_SHIFT-1:0] bx;
    logic [DIR_SHIFT-1:0] by;
    logic [SLOT_W-1:0]    slot;
    logic [CELL_W-1:0]    cell_idx;
    grid_result_t         res;
    bx = DIR_SHIFT'(x >> BLOCK_SHIFT);
    by = DIR_SHIFT'(y >> BLOCK_SHIFT);
    slot = {bx, by};
    cell_idx = {x[BLOCK_SHIFT-1:0], y[BLOCK_SHIFT-1:0]};
    res.read_value = '0;
    res.status = STATUS_DONE;
    if (f == FUNC_READ) begin
      if (slot_used[slot]) begin
        res.read_value = grid_cells[{slot_block[slot], cell_idx}];
      end
    end else begin
      if (!slot_used[slot] && pool_taken < POOL_BLOCKS) begin
        slot_used[slot] = 1'b1;
        slot_block[slot] = BLK_W'(pool_taken);
        for (int i = 0; i < (1 << CELL_W); i++) begin
          grid_cells[{BLK_W'(pool_taken), CELL_W'(i)}] = '0;
        end
        pool_taken++;
      end
      if (slot_used[slot]) begin
        grid_cells[{slot_block[slot], cell_idx}] = v;
      end else begin
        res.status = STATUS_DROPPED;
        drop_count++;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    grid_result_t want;
    grid_result_t got;
    if (!rst_n) begin
      for (int i = 0; i < DIR_DEPTH; i++) begin
        slot_used[i] = 1'b0;
        slot_block[i] = '0;
      end
      for (int i = 0; i < STORE_DEPTH; i++) begin
        grid_cells[i] = '0;
      end
      pool_taken = 0;
      drop_count = 0;
      grid_result_q.delete();
      requests_seen <= 0;
      results_checked <= 0;
      mismatches <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.read_value = out_read_value;
        got.status = out_status;
        if (grid_result_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("unexpected result: read_value %0d status %0d", got.read_value,
                     got.status);
          end
        end else begin
          want = grid_result_q.pop_front();
          results_checked <= results_checked + 1;
          if (got.read_value !== want.read_value || got.status !== want.status) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("result %0d: expected read_value %0d status %0d, got %0d status %0d",
                       results_checked, want.read_value, want.status, got.read_value,
                       got.status);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        grid_result_q.push_back(grid_access(in_func, in_x_coord, in_y_coord,
                                            in_write_value));
        requests_seen <= requests_seen + 1;
      end
    end
  end

endmodule

// ===== verif/tb_sparse_grid_block_store.sv =====
module tb_sparse_grid_block_store;
  import sgbs_pkg::*;

  localparam int IDLE_LIMIT      = 20000;
  localparam int RANDOM_REQUESTS = 1700;
  localparam int HI_W            = COORD_W - BLOCK_SHIFT;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_func        = FUNC_READ;
  logic [COORD_W-1:0] in_x_coord     = '0;
  logic [COORD_W-1:0] in_y_coord     = '0;
  logic [VALUE_W-1:0] in_write_value = '0;
  logic               out_stall      = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [VALUE_W-1:0] out_read_value;
  logic               out_status;

  int mismatches;
  int pending;
  int results_checked;
  int writes_dropped;
  int blocks_allocated;
  int idle_cycles = 0;
  int stall_left  = 0;
  int burst_left  = 0;
  int requests_sent = 0;

  logic [HI_W-1:0] hot_bx[$];
  logic [HI_W-1:0] hot_by[$];
  bit              block_seen [DIR_DEPTH];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sparse_grid_block_store u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

  sgbs_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_x_coord       (in_x_coord),
    .in_y_coord       (in_y_coord),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_value   (out_read_value),
    .out_status       (out_status),
    .mismatches       (mismatches),
    .pending          (pending),
    .results_checked  (results_checked),
    .writes_dropped   (writes_dropped),
    .blocks_allocated (blocks_allocated)
  );

  function automatic int pause_len();
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall <= 1'b1;
      stall_left <= pause_len() - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                 : $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no progress for %0d cycles, %0d results outstanding", IDLE_LIMIT, pending);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(input logic f, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [VALUE_W-1:0] v);
    int                gap;
    logic [SLOT_W-1:0] blk;
    in_valid <= 1'b1;
    in_func <= f;
    in_x_coord <= x;
    in_y_coord <= y;
    in_write_value <= v;
    blk = {x[COORD_W-1:BLOCK_SHIFT], y[COORD_W-1:BLOCK_SHIFT]};
    if (f == FUNC_WRITE && !block_seen[blk]) begin
      block_seen[blk] = 1'b1;
      hot_bx.push_back(x[COORD_W-1:BLOCK_SHIFT]);
      hot_by.push_back(y[COORD_W-1:BLOCK_SHIFT]);
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = ($urandom_range(0, 99) < 65) ? 0 : pause_len();
      if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    logic               f;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [VALUE_W-1:0] v;
    int                 k;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_request(FUNC_READ,  10'd0,    10'd0,    8'h5a);
    send_request(FUNC_WRITE, 10'd0,    10'd0,    8'hff);
    send_request(FUNC_READ,  10'd0,    10'd0,    8'h00);
    send_request(FUNC_READ,  10'd15,   10'd15,   8'hff);
    send_request(FUNC_WRITE, 10'd15,   10'd15,   8'h01);
    send_request(FUNC_READ,  10'd15,   10'd15,   8'h00);
    send_request(FUNC_WRITE, 10'd0,    10'd0,    8'h00);
    send_request(FUNC_READ,  10'd0,    10'd0,    8'hff);
    send_request(FUNC_WRITE, 10'd1023, 10'd1023, 8'hff);
    send_request(FUNC_READ,  10'd1023, 10'd1023, 8'h00);
    send_request(FUNC_WRITE, 10'd1008, 10'd1008, 8'h80);
    send_request(FUNC_READ,  10'd1008, 10'd1008, 8'h7f);
    send_request(FUNC_READ,  10'd1023, 10'd0,    8'hff);
    send_request(FUNC_WRITE, 10'h2aa,  10'h155,  8'ha5);
    send_request(FUNC_READ,  10'h2aa,  10'h155,  8'h5a);
    send_request(FUNC_WRITE, 10'h155,  10'h2aa,  8'h5a);
    send_request(FUNC_READ,  10'h155,  10'h2aa,  8'ha5);
    send_request(FUNC_READ,  10'h2aa,  10'h2aa,  8'h00);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (hot_bx.size() == 0 || $urandom_range(0, 99) < 12) begin
        x = COORD_W'($urandom());
        y = COORD_W'($urandom());
        f = ($urandom_range(0, 1) == 1) ? FUNC_WRITE : FUNC_READ;
      end else begin
        k = $urandom_range(0, hot_bx.size() - 1);
        x = {hot_bx[k], BLOCK_SHIFT'($urandom())};
        y = {hot_by[k], BLOCK_SHIFT'($urandom())};
        f = ($urandom_range(0, 99) < 45) ? FUNC_WRITE : FUNC_READ;
      end
      v = VALUE_W'($urandom());
      send_request(f, x, y, v);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d requests sent, %0d results checked, %0d mismatches", requests_sent,
             results_checked, mismatches);
    $display("%0d of %0d pool blocks allocated, %0d writes dropped on a full pool",
             blocks_allocated, POOL_BLOCKS, writes_dropped);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sgbs_pkg.sv
hw/rtl/sgbs_ram.sv
hw/rtl/sparse_grid_block_store.sv
verif/sgbs_checker.sv
verif/tb_sparse_grid_block_store.sv
